@@ src/xcr_pkg.sv @@
// Shared types, character constants and decode functions for the XML reference decoder.
package xcr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 17;
  localparam int unsigned CountW = 4;
  localparam int unsigned MaxRes = 3;

  localparam logic [CountW-1:0] MaxChars = 4'd7;

  localparam logic [ByteW-1:0] ChAmp   = 8'h26;
  localparam logic [ByteW-1:0] ChApos  = 8'h27;
  localparam logic [ByteW-1:0] ChQuot  = 8'h22;
  localparam logic [ByteW-1:0] ChLt    = 8'h3C;
  localparam logic [ByteW-1:0] ChGt    = 8'h3E;
  localparam logic [ByteW-1:0] ChSemi  = 8'h3B;
  localparam logic [ByteW-1:0] ChHash  = 8'h23;
  localparam logic [ByteW-1:0] ChLowA  = 8'h61;
  localparam logic [ByteW-1:0] ChLowG  = 8'h67;
  localparam logic [ByteW-1:0] ChLowL  = 8'h6C;
  localparam logic [ByteW-1:0] ChLowM  = 8'h6D;
  localparam logic [ByteW-1:0] ChLowO  = 8'h6F;
  localparam logic [ByteW-1:0] ChLowP  = 8'h70;
  localparam logic [ByteW-1:0] ChLowQ  = 8'h71;
  localparam logic [ByteW-1:0] ChLowS  = 8'h73;
  localparam logic [ByteW-1:0] ChLowT  = 8'h74;
  localparam logic [ByteW-1:0] ChLowU  = 8'h75;
  localparam logic [ByteW-1:0] ChLowX  = 8'h78;

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_A    = 9'b000000010,
    PH_AMP  = 9'b000000100,
    PH_APOS = 9'b000001000,
    PH_GTLT = 9'b000010000,
    PH_QUOT = 9'b000100000,
    PH_HASH = 9'b001000000,
    PH_HEX  = 9'b010000000,
    PH_DEC  = 9'b100000000
  } xcr_phase_e;

  // Up to three UTF-8 bytes from one request, byte 0 goes out first
  typedef struct packed {
    logic [1:0]                   cnt;
    logic                         err;
    logic [CountW-1:0]            len;
    logic [MaxRes-1:0][ByteW-1:0] bytes;
  } xcr_res_t;

  function automatic xcr_res_t error_res();
    xcr_res_t r;
    r       = '0;
    r.cnt   = 2'd1;
    r.err   = 1'b1;
    return r;
  endfunction

  function automatic xcr_res_t char_res(input logic [ByteW-1:0] ch,
                                        input logic [CountW-1:0] len);
    xcr_res_t r;
    r          = '0;
    r.cnt      = 2'd1;
    r.len      = len;
    r.bytes[0] = ch;
    return r;
  endfunction

  function automatic xcr_res_t utf8_encode(input logic [CodeW-1:0] ch,
                                           input logic [CountW-1:0] len);
    xcr_res_t r;
    r     = '0;
    r.len = len;
    if (ch < 17'h00080) begin
      if (ch >= 17'h00020 || ch == 17'h00009 || ch == 17'h0000A || ch == 17'h0000D) begin
        r.cnt      = 2'd1;
        r.bytes[0] = ch[7:0];
      end else begin
        r = error_res();
      end
    end else if (ch < 17'h00800) begin
      r.cnt      = 2'd2;
      r.bytes[0] = 8'hC0 | {3'b000, ch[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, ch[5:0]};
    end else if (ch < 17'h10000) begin
      r.cnt      = 2'd3;
      r.bytes[0] = 8'hE0 | {4'b0000, ch[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, ch[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, ch[5:0]};
    end else begin
      r = error_res();
    end
    return r;
  endfunction

  // Expected byte of a named reference at a position; bit 8 flags a valid position
  function automatic logic [ByteW:0] name_expect(input xcr_phase_e ph,
                                                 input logic [CountW-1:0] pos);
    logic [ByteW:0] e;
    e = '0;
    case (ph)
      PH_AMP: begin
        case (pos)
          4'd3:    e = {1'b1, ChLowP};
          4'd4:    e = {1'b1, ChSemi};
          default: e = '0;
        endcase
      end
      PH_APOS: begin
        case (pos)
          4'd3:    e = {1'b1, ChLowO};
          4'd4:    e = {1'b1, ChLowS};
          4'd5:    e = {1'b1, ChSemi};
          default: e = '0;
        endcase
      end
      PH_GTLT: begin
        case (pos)
          4'd2:    e = {1'b1, ChLowT};
          4'd3:    e = {1'b1, ChSemi};
          default: e = '0;
        endcase
      end
      PH_QUOT: begin
        case (pos)
          4'd2:    e = {1'b1, ChLowU};
          4'd3:    e = {1'b1, ChLowO};
          4'd4:    e = {1'b1, ChLowT};
          4'd5:    e = {1'b1, ChSemi};
          default: e = '0;
        endcase
      end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

@@ src/xcr_parser.sv @@
// Reference parser: phase, accumulated code point and character count, one byte per request.
module xcr_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [xcr_pkg::ByteW-1:0] byte_i,
  input  logic                     begin_i,
  output xcr_pkg::xcr_res_t        res_o
);
  import xcr_pkg::*;

  xcr_phase_e        phase_q, phase_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  first_q, first_d;

  logic              dec_path, hex_path, is_semi, dig_ok;
  logic [3:0]        dig_val;
  logic [CodeW-1:0]  code_next;
  logic [CountW-1:0] cnt_inc;
  logic [ByteW:0]    expect_w;
  logic [ByteW-1:0]  named_ch;

  assign is_semi  = (byte_i == ChSemi);
  assign dec_path = (phase_q == PH_HASH && byte_i != ChLowX) || phase_q == PH_DEC;
  assign hex_path = (phase_q == PH_HEX);
  assign cnt_inc  = cnt_q + 4'd1;
  assign expect_w = name_expect(phase_q, cnt_q);

  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (byte_i inside {[8'h30:8'h39]}) begin
      dig_ok  = 1'b1;
      dig_val = byte_i[3:0];
    end else if (hex_path && (byte_i inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
      dig_ok  = 1'b1;
      dig_val = byte_i[3:0] + 4'd9;
    end
  end

  // Decimal: code*10 as two shifts; hex: shift in a nibble
  assign code_next = hex_path ? {code_q[CodeW-5:0], dig_val}
                              : (code_q << 3) + (code_q << 1) + {13'd0, dig_val};

  always_comb begin
    case (phase_q)
      PH_AMP:  named_ch = ChAmp;
      PH_APOS: named_ch = ChApos;
      PH_GTLT: named_ch = (first_q == ChLowL) ? ChLt : ChGt;
      PH_QUOT: named_ch = ChQuot;
      default: named_ch = '0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    res_o   = '0;
    if (begin_i) begin
      first_d = byte_i;
      code_d  = '0;
      cnt_d   = 4'd2;
      case (byte_i)
        ChLowA:         phase_d = PH_A;
        ChLowG, ChLowL: phase_d = PH_GTLT;
        ChLowQ:         phase_d = PH_QUOT;
        ChHash:         phase_d = PH_HASH;
        default: begin
          phase_d = PH_IDLE;
          res_o   = error_res();
        end
      endcase
    end else if (dec_path || hex_path) begin
      if (is_semi) begin
        cnt_d   = cnt_inc;
        phase_d = PH_IDLE;
        res_o   = utf8_encode(code_q, cnt_inc);
      end else if (!dig_ok || cnt_q >= MaxChars) begin
        phase_d = PH_IDLE;
        res_o   = error_res();
      end else begin
        code_d  = code_next;
        cnt_d   = cnt_inc;
        phase_d = hex_path ? PH_HEX : PH_DEC;
      end
    end else begin
      case (phase_q)
        PH_A: begin
          cnt_d = 4'd3;
          if (byte_i == ChLowM) begin
            phase_d = PH_AMP;
          end else if (byte_i == ChLowP) begin
            phase_d = PH_APOS;
          end else begin
            phase_d = PH_IDLE;
            res_o   = error_res();
          end
        end
        PH_AMP, PH_APOS, PH_GTLT, PH_QUOT: begin
          if (!expect_w[ByteW] || byte_i != expect_w[ByteW-1:0]) begin
            phase_d = PH_IDLE;
            res_o   = error_res();
          end else begin
            cnt_d = cnt_inc;
            if (is_semi) begin
              phase_d = PH_IDLE;
              res_o   = char_res(named_ch, cnt_inc);
            end
          end
        end
        PH_HASH: begin
          // only the lowercase x reaches here, other bytes take the decimal path
          phase_d = PH_HEX;
          cnt_d   = 4'd3;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    if (!fire_i) begin
      res_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      code_q  <= '0;
      cnt_q   <= '0;
      first_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

endmodule

@@ src/xcr_out_buf.sv @@
// Result register: holds up to three UTF-8 bytes and hands them out one per cycle while ready_i is high.
module xcr_out_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  xcr_pkg::xcr_res_t         res_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [xcr_pkg::ByteW-1:0] byte_o,
  output logic                      err_o,
  output logic [xcr_pkg::CountW-1:0] len_o,
  output logic                      last_o,
  output logic                      free_o
);
  import xcr_pkg::*;

  logic              valid_q, valid_d;
  logic [1:0]        idx_q, idx_d;
  xcr_res_t          res_q;
  logic              take;

  assign take    = valid_q && ready_i;
  assign last_o  = (idx_q == res_q.cnt - 2'd1);
  assign valid_o = valid_q;
  assign byte_o  = (idx_q < 2'd3) ? res_q.bytes[idx_q] : '0;
  assign err_o   = res_q.err;
  assign len_o   = res_q.len;
  // free when empty or the final byte leaves this cycle
  assign free_o  = !valid_q || (take && last_o);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (take) begin
      if (last_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ src/xml_char_reference_decoder.sv @@
// A result byte is registered and appears in the cycle after the request that completes a reference.
// One input byte per cycle while m_axis_tready is high; a character of two or three UTF-8 bytes holds
// the input while the result register drains.
// Bytes inside a reference give no result and are taken at one per cycle.
// Reset (rst_ni low, asynchronous) returns the parser to idle and empties the result register.
module xml_char_reference_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] begin_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] ref_length, [15:12] zero
  output logic        m_axis_tuser,   // [0] is_error
  output logic        m_axis_tlast    // last
);
  import xcr_pkg::*;

  logic              fire, free;
  xcr_res_t          res;
  logic [ByteW-1:0]  out_byte;
  logic [CountW-1:0] out_len;

  assign s_axis_tready = free;
  assign fire          = s_axis_tvalid && free;

  xcr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .begin_i(s_axis_tuser),
    .res_o  (res)
  );

  xcr_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && res.cnt != 2'd0),
    .res_i  (res),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .byte_o (out_byte),
    .err_o  (m_axis_tuser),
    .len_o  (out_len),
    .last_o (m_axis_tlast),
    .free_o (free)
  );

  assign m_axis_tdata = {4'b0000, out_len, out_byte};

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[11:8] == 4'd0)
    else $error("error result not final or with nonzero length");

  a_no_take_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast && m_axis_tready)
    else $error("request taken while a character is still draining");

  a_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |=> m_axis_tvalid)
    else $error("character dropped before its final byte");
`endif

endmodule
